// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, constants, types and helpers for the pixel tint colourizer.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Fixed-point unity and its fraction width
    localparam int FIXED_ONE  = 65536;
    localparam int FRAC_W     = 16;
    localparam int MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int H_W     = 13;
    localparam int GAIN_W  = 17;
    localparam int BGAIN_W = 18;
    localparam int COFF_W  = 17;
    localparam int COFFT_W = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_RED        = 3'd0,
        REG_TINT_GREEN      = 3'd1,
        REG_TINT_BLUE       = 3'd2,
        REG_IMAGE_HEIGHT    = 3'd3,
        REG_USE_ALPHA       = 3'd4,
        REG_BRIGHTNESS_GAIN = 3'd5,
        REG_CONTRAST_OFFSET = 3'd6,
        REG_DARK_LEVEL      = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [PIX_W-1:0]   RST_TINT     = 8'd255;
    localparam logic [H_W-1:0]     RST_HEIGHT   = 13'd1;
    localparam logic [BGAIN_W-1:0] RST_BGAIN    = 18'd62914;
    localparam logic [COFF_W-1:0]  RST_COFF     = 17'd7864;
    localparam logic [GAIN_W-1:0]  RST_DARK     = 17'd18350;

    // Luminance weights (sum 256)
    localparam int LUM_COEF_R = 54;
    localparam int LUM_COEF_G = 183;
    localparam int LUM_COEF_B = 19;

    // ceil(2^16 / 3): exact x/3 for x below 2^14
    localparam int THIRD_RECIP = 21846;

    localparam logic [GAIN_W-1:0] FULL_GAIN = GAIN_W'(FIXED_ONE);

    // Row-gain divider geometry
    localparam int DEN_W      = 12;
    localparam int MAG_W      = 28;
    localparam int QUO_W      = 18;
    localparam int ACC_W      = DEN_W + QUO_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // Latencies, accept edge to result edge
    localparam int GAIN_LAT = DIV_STAGES + 3;
    localparam int TINT_LAT = 6;
    localparam int PIPE_LAT = 1 + GAIN_LAT + TINT_LAT;

    localparam int LANES = 3;

    // Per-pixel sideband carried through the gain pipeline
    typedef struct packed {
        logic [PIX_W-1:0] lum;
        logic [PIX_W-1:0] alpha;
    } pix_ctx_t;

    // Configuration seen by the row-gain pipeline
    typedef struct packed {
        logic [H_W-1:0]    height;
        logic [DEN_W-1:0]  top_third;
        logic [H_W-1:0]    low_third;
        logic [GAIN_W-1:0] dark;
    } gain_cfg_t;

    // Configuration seen by the tint pipeline
    typedef struct packed {
        logic [LANES-1:0][PIX_W-1:0] tint;
        logic                        use_alpha;
        logic [BGAIN_W-1:0]          bgain;
        logic [COFFT_W-1:0]          coff_term;
    } tint_cfg_t;

    // One slot of the row-gain divider
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [DEN_W-1:0]  den;
        logic [GAIN_W-1:0] base;
        logic              neg;
        pix_ctx_t          ctx;
    } div_work_t;

    // floor(x / 255), exact for x below 65280
    function automatic logic [PIX_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'd1 + 17'(x[15:8]);
        return s[15:8];
    endfunction

endpackage

// ===== rtl/pixel_tint_colorize.sv =====
// ----------------------------------------------------------------------------
// pixel_tint_colorize
// Luminance-driven tint colourizer with vertical edge darkening.
// ----------------------------------------------------------------------------
// Takes one pixel per clock once busy is low and returns its colourized value,
// strobed by done for one cycle, after the pipeline: input register, band
// select, ramp product, six divider slots of three quotient bits each, gain
// combine, and six tint stages. There is no back-pressure; the receiver must
// take every done. busy is high from reset until the derived row thresholds
// have settled, falling in the cycle after reset is released, and low from
// then on. The user must write registers only between frames, when no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pixel_tint_colorize (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ptc_pkg::PIX_W-1:0]        in_red,
    input  logic [ptc_pkg::PIX_W-1:0]        in_green,
    input  logic [ptc_pkg::PIX_W-1:0]        in_blue,
    input  logic [ptc_pkg::PIX_W-1:0]        in_alpha,
    input  logic [ptc_pkg::ROW_W-1:0]        row,
    output logic                             done,
    output logic [ptc_pkg::PIX_W-1:0]        out_red,
    output logic [ptc_pkg::PIX_W-1:0]        out_green,
    output logic [ptc_pkg::PIX_W-1:0]        out_blue,
    input  logic                             cfg_write,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ptc_pkg::*;

    localparam int TOP_PROD_W  = H_W + FRAC_W;
    localparam int LOW_PROD_W  = H_W + 1 + FRAC_W;
    localparam int COFF_PROD_W = COFF_W + PIX_W;

    // Configuration registers
    logic [PIX_W-1:0]   tint_red_reg, tint_green_reg, tint_blue_reg;
    logic [H_W-1:0]     height_reg;
    logic               use_alpha_reg;
    logic [BGAIN_W-1:0] bgain_reg;
    logic [COFF_W-1:0]  coff_reg;
    logic [GAIN_W-1:0]  dark_reg;

    // Values derived from configuration
    logic [TOP_PROD_W-1:0]  top_prod;
    logic [LOW_PROD_W-1:0]  low_prod;
    logic [COFF_PROD_W-1:0] coff_prod;
    logic [DEN_W-1:0]       top_third_reg;
    logic [H_W-1:0]         low_third_reg;
    logic [COFFT_W-1:0]     coff_term_reg;

    logic busy_reg;

    // Input register
    logic             in_valid_reg;
    logic [PIX_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [ROW_W-1:0] row_reg;
    logic [15:0]      lum_sum;

    pix_ctx_t  ctx_in, ctx_gain;
    gain_cfg_t gain_cfg;
    tint_cfg_t tint_cfg;
    logic              gain_valid;
    logic [GAIN_W-1:0] gain;
    logic [LANES-1:0][PIX_W-1:0] pix_out;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_red_reg   <= RST_TINT;
            tint_green_reg <= RST_TINT;
            tint_blue_reg  <= RST_TINT;
            height_reg     <= RST_HEIGHT;
            use_alpha_reg  <= 1'b0;
            bgain_reg      <= RST_BGAIN;
            coff_reg       <= RST_COFF;
            dark_reg       <= RST_DARK;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TINT_RED:        tint_red_reg   <= cfg_data[PIX_W-1:0];
                REG_TINT_GREEN:      tint_green_reg <= cfg_data[PIX_W-1:0];
                REG_TINT_BLUE:       tint_blue_reg  <= cfg_data[PIX_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg     <= cfg_data[H_W-1:0];
                REG_USE_ALPHA:       use_alpha_reg  <= cfg_data[0];
                REG_BRIGHTNESS_GAIN: bgain_reg      <= cfg_data[BGAIN_W-1:0];
                REG_CONTRAST_OFFSET: coff_reg       <= cfg_data[COFF_W-1:0];
                REG_DARK_LEVEL:      dark_reg       <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // Band thresholds H/3, 2H/3 by reciprocal, and the contrast term
    assign top_prod  = TOP_PROD_W'(height_reg) * TOP_PROD_W'(THIRD_RECIP);
    assign low_prod  = LOW_PROD_W'({height_reg, 1'b0}) * LOW_PROD_W'(THIRD_RECIP);
    assign coff_prod = COFF_PROD_W'(coff_reg) * COFF_PROD_W'(255);

    always_ff @(posedge clk)
    begin
        top_third_reg <= top_prod[FRAC_W+DEN_W-1:FRAC_W];
        low_third_reg <= low_prod[FRAC_W+H_W-1:FRAC_W];
        coff_term_reg <= coff_prod[COFF_PROD_W-1:FRAC_W];
    end

    // Busy until the derived values are valid after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= start && !busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= in_red;
        green_reg <= in_green;
        blue_reg  <= in_blue;
        alpha_reg <= in_alpha;
        row_reg   <= row;
    end

    // Luminance, weights sum to 256
    assign lum_sum = 16'(red_reg)   * 16'(LUM_COEF_R)
                   + 16'(green_reg) * 16'(LUM_COEF_G)
                   + 16'(blue_reg)  * 16'(LUM_COEF_B);

    assign ctx_in.lum   = lum_sum[15:8];
    assign ctx_in.alpha = alpha_reg;

    assign gain_cfg.height    = height_reg;
    assign gain_cfg.top_third = top_third_reg;
    assign gain_cfg.low_third = low_third_reg;
    assign gain_cfg.dark      = dark_reg;

    assign tint_cfg.tint[0]   = tint_red_reg;
    assign tint_cfg.tint[1]   = tint_green_reg;
    assign tint_cfg.tint[2]   = tint_blue_reg;
    assign tint_cfg.use_alpha = use_alpha_reg;
    assign tint_cfg.bgain     = bgain_reg;
    assign tint_cfg.coff_term = coff_term_reg;

    ptc_row_gain u_row_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid_reg),
        .row       (row_reg),
        .ctx_in    (ctx_in),
        .cfg       (gain_cfg),
        .valid_out (gain_valid),
        .gain      (gain),
        .ctx_out   (ctx_gain)
    );

    ptc_tint u_tint (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (gain_valid),
        .gain      (gain),
        .ctx_in    (ctx_gain),
        .cfg       (tint_cfg),
        .valid_out (done),
        .pix_out   (pix_out)
    );

    assign busy      = busy_reg;
    assign out_red   = pix_out[0];
    assign out_green = pix_out[1];
    assign out_blue  = pix_out[2];

    // Every result traces back to an accepted transaction a fixed time earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching accepted transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after start-up");

endmodule

// ===== rtl/ptc_div_stage.sv =====
// ----------------------------------------------------------------------------
// ptc_div_stage
// One registered slot of the row-gain divider: DIV_STEPS restoring steps.
// ----------------------------------------------------------------------------
module ptc_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  ptc_pkg::div_work_t work_in,
    output logic               valid_out,
    output ptc_pkg::div_work_t work_out
);
    import ptc_pkg::*;

    logic      valid_reg;
    div_work_t work_reg;
    div_work_t work_next;

    // Restoring steps: remainder in the top bits, quotient shifts in below
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        logic [DEN_W:0]   trial;
        logic             fits;
        acc = work_in.acc;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial = acc[ACC_W-1:QUO_W-1];
            fits  = (trial >= {1'b0, work_in.den});
            if (fits)
            begin
                trial = trial - {1'b0, work_in.den};
            end
            acc = {trial[DEN_W-1:0], acc[QUO_W-2:0], fits};
        end
        work_next     = work_in;
        work_next.acc = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

// ===== rtl/ptc_row_gain.sv =====
// ----------------------------------------------------------------------------
// ptc_row_gain
// Vertical gain ramp: band select, ramp product, pipelined divide, combine.
// ----------------------------------------------------------------------------
module ptc_row_gain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic [ptc_pkg::ROW_W-1:0]    row,
    input  ptc_pkg::pix_ctx_t            ctx_in,
    input  ptc_pkg::gain_cfg_t           cfg,
    output logic                         valid_out,
    output logic [ptc_pkg::GAIN_W-1:0]   gain,
    output ptc_pkg::pix_ctx_t            ctx_out
);
    import ptc_pkg::*;

    // Band select stage
    logic              sel_valid_reg;
    logic [ROW_W-1:0]  pos_reg,     pos_next;
    logic [DEN_W-1:0]  den_reg,     den_next;
    logic [GAIN_W-1:0] base_reg,    base_next;
    logic              neg_reg,     neg_next;
    logic [GAIN_W-1:0] absdiff_reg, absdiff_next;
    pix_ctx_t          sel_ctx_reg;

    // Product stage
    logic              mul_valid_reg;
    div_work_t         mul_work_reg, mul_work_next;
    logic [ROW_W+GAIN_W-1:0] mag_full;

    // Divider chain
    logic              div_valid [DIV_STAGES+1];
    div_work_t         div_work  [DIV_STAGES+1];

    // Combine stage
    logic              out_valid_reg;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    pix_ctx_t          out_ctx_reg;
    logic [QUO_W-1:0]  quo;

    logic [H_W-1:0]    row_ext;
    logic              dark_above;

    assign row_ext    = H_W'(row);
    assign dark_above = (cfg.dark > FULL_GAIN);

    // Which band, and the ramp terms; fixed gains use pos 0 over 1
    always_comb
    begin
        pos_next     = '0;
        den_next     = DEN_W'(1);
        base_next    = FULL_GAIN;
        neg_next     = 1'b0;
        absdiff_next = dark_above ? (cfg.dark - FULL_GAIN) : (FULL_GAIN - cfg.dark);
        if (row_ext <= H_W'(cfg.top_third))
        begin
            if (row == '0)
            begin
                base_next = cfg.dark;
            end
            else if (row_ext < H_W'(cfg.top_third))
            begin
                pos_next  = row;
                den_next  = cfg.top_third;
                base_next = cfg.dark;
                neg_next  = dark_above;
            end
        end
        else if (row_ext >= cfg.low_third && row_ext < cfg.height)
        begin
            if (row_ext != cfg.low_third)
            begin
                pos_next = ROW_W'(row_ext - cfg.low_third);
                den_next = DEN_W'(cfg.height - cfg.low_third);
                neg_next = (cfg.dark < FULL_GAIN);
            end
        end
    end

    // Ramp product feeds the divider
    assign mag_full = (ROW_W+GAIN_W)'(pos_reg) * (ROW_W+GAIN_W)'(absdiff_reg);

    always_comb
    begin
        mul_work_next.acc  = ACC_W'(mag_full[MAG_W-1:0]);
        mul_work_next.den  = den_reg;
        mul_work_next.base = base_reg;
        mul_work_next.neg  = neg_reg;
        mul_work_next.ctx  = sel_ctx_reg;
    end

    assign div_valid[0] = mul_valid_reg;
    assign div_work[0]  = mul_work_reg;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        ptc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (div_valid[i]),
            .work_in   (div_work[i]),
            .valid_out (div_valid[i+1]),
            .work_out  (div_work[i+1])
        );
    end

    // Apply the signed quotient to the band's base gain
    assign quo = div_work[DIV_STAGES].acc[QUO_W-1:0];

    always_comb
    begin
        if (div_work[DIV_STAGES].neg)
        begin
            gain_next = div_work[DIV_STAGES].base - quo[GAIN_W-1:0];
        end
        else
        begin
            gain_next = div_work[DIV_STAGES].base + quo[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg <= valid_in;
            mul_valid_reg <= sel_valid_reg;
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        den_reg      <= den_next;
        base_reg     <= base_next;
        neg_reg      <= neg_next;
        absdiff_reg  <= absdiff_next;
        sel_ctx_reg  <= ctx_in;
        mul_work_reg <= mul_work_next;
        gain_reg     <= gain_next;
        out_ctx_reg  <= div_work[DIV_STAGES].ctx;
    end

    assign valid_out = out_valid_reg;
    assign gain      = gain_reg;
    assign ctx_out   = out_ctx_reg;

    // Dividend is always below den * 2^17, so the divide settles cleanly
    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[DIV_STAGES] |->
            (div_work[DIV_STAGES].acc[ACC_W-1:QUO_W] < div_work[DIV_STAGES].den))
        else $error("row gain divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[DIV_STAGES] |-> !quo[QUO_W-1])
        else $error("row gain quotient exceeds ramp span");

endmodule

// ===== rtl/ptc_tint.sv =====
// ----------------------------------------------------------------------------
// ptc_tint
// Gained luminance, brightness/contrast level, tint scaling and alpha scaling.
// ----------------------------------------------------------------------------
module ptc_tint (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      valid_in,
    input  logic [ptc_pkg::GAIN_W-1:0]                gain,
    input  ptc_pkg::pix_ctx_t                         ctx_in,
    input  ptc_pkg::tint_cfg_t                        cfg,
    output logic                                      valid_out,
    output logic [ptc_pkg::LANES-1:0][ptc_pkg::PIX_W-1:0] pix_out
);
    import ptc_pkg::*;

    localparam int LG_PROD_W = PIX_W + GAIN_W;
    localparam int LV_PROD_W = PIX_W + BGAIN_W;
    localparam int LV_SUM_W  = LV_PROD_W - FRAC_W + 1;

    logic [TINT_LAT-1:0] valid_reg;

    // Stage 1: luminance times row gain, clipped
    logic [LG_PROD_W-1:0]       lg_prod;
    logic [PIX_W-1:0]           lumg_reg, lumg_next;
    logic [PIX_W-1:0]           alpha1_reg;

    // Stage 2: level
    logic [LV_PROD_W-1:0]       lv_prod;
    logic [LV_SUM_W-1:0]        lv_sum;
    logic [PIX_W-1:0]           level_reg, level_next;
    logic [PIX_W-1:0]           alpha2_reg;

    // Stages 3..6: per-lane tint and alpha
    logic [LANES-1:0][15:0]     tprod_reg;
    logic [PIX_W-1:0]           alpha3_reg;
    logic [LANES-1:0][PIX_W-1:0] tval_reg;
    logic [PIX_W-1:0]           alpha4_reg;
    logic [LANES-1:0][15:0]     aprod_reg;
    logic [LANES-1:0][PIX_W-1:0] tval5_reg;
    logic                       scale5_reg;
    logic [LANES-1:0][PIX_W-1:0] pix_reg, pix_next;

    // Gained luminance
    assign lg_prod = LG_PROD_W'(ctx_in.lum) * LG_PROD_W'(gain);

    always_comb
    begin
        if (lg_prod[LG_PROD_W-1:FRAC_W] > (LG_PROD_W-FRAC_W)'(255))
        begin
            lumg_next = 8'hff;
        end
        else
        begin
            lumg_next = lg_prod[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    // Brightness gain plus contrast term, clipped
    assign lv_prod = LV_PROD_W'(lumg_reg) * LV_PROD_W'(cfg.bgain);
    assign lv_sum  = LV_SUM_W'(lv_prod[LV_PROD_W-1:FRAC_W]) + LV_SUM_W'(cfg.coff_term);

    always_comb
    begin
        if (lv_sum > LV_SUM_W'(255))
        begin
            level_next = 8'hff;
        end
        else
        begin
            level_next = lv_sum[PIX_W-1:0];
        end
    end

    // Final pick: alpha-scaled only in alpha mode with alpha below opaque
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            pix_next[k] = scale5_reg ? div255(aprod_reg[k]) : tval5_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[TINT_LAT-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        lumg_reg   <= lumg_next;
        alpha1_reg <= ctx_in.alpha;
        level_reg  <= level_next;
        alpha2_reg <= alpha1_reg;
        alpha3_reg <= alpha2_reg;
        alpha4_reg <= alpha3_reg;
        scale5_reg <= cfg.use_alpha && (alpha4_reg != 8'hff);
        for (int k = 0; k < LANES; k++)
        begin
            tprod_reg[k] <= 16'(level_reg) * 16'(cfg.tint[k]);
            tval_reg[k]  <= div255(tprod_reg[k]);
            aprod_reg[k] <= 16'(tval_reg[k]) * 16'(alpha4_reg);
            tval5_reg[k] <= tval_reg[k];
        end
        pix_reg <= pix_next;
    end

    assign valid_out = valid_reg[TINT_LAT-1];
    assign pix_out   = pix_reg;

endmodule

// ===== tb/pixel_tint_colorize_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_tint_colorize_tb
// Self-checking bench for the pixel tint colouriser.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers the register reset state, the
// extremes of every register and field, zero and very small heights, the top
// and bottom ramps, a dark level above unity, and alpha on and off. Rows whose
// result is obvious carry it typed in, and the others go to the predictor.
// After that come random phases, each with fresh register settings and bursts
// of random pixels with random gaps. Every transaction is predicted when it is
// accepted, and every done is compared lane by lane with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_tint_colorize_tb;
    import ptc_pkg::*;

    localparam int LIMIT      = 300000;
    localparam int SETTLE     = 4;
    localparam int RAND_ITEMS = 1000;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic [ROW_W-1:0] row;
    } pixel_t;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct {
        bit                    is_write;
        cfg_reg_t              reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
        pixel_t                px;
        bit                    typed;
        rgb_t                  want;
    } plan_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PIX_W-1:0]      in_red;
    logic [PIX_W-1:0]      in_green;
    logic [PIX_W-1:0]      in_blue;
    logic [PIX_W-1:0]      in_alpha;
    logic [ROW_W-1:0]      row;
    logic                  done;
    logic [PIX_W-1:0]      out_red;
    logic [PIX_W-1:0]      out_green;
    logic [PIX_W-1:0]      out_blue;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the register file, as the predictor sees it
    logic [PIX_W-1:0]   tint_q [LANES];
    logic [H_W-1:0]     height_q   = RST_HEIGHT;
    logic               alpha_on_q = 1'b0;
    logic [BGAIN_W-1:0] bgain_q    = RST_BGAIN;
    logic [COFF_W-1:0]  coff_q     = RST_COFF;
    logic [GAIN_W-1:0]  dark_q     = RST_DARK;

    rgb_t       tinted_q [$];
    plan_step_t plan_q   [$];

    int fault_cnt    = 0;
    int results_seen = 0;
    int pixels_sent  = 0;
    int settings_cnt = 1;
    int cycle_cnt    = 0;

    pixel_tint_colorize u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .row       (row),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_to_byte(input longint v);
        if (v <= 0)
            return 0;
        if (v >= 255)
            return 255;
        return v;
    endfunction

    // Vertical gain: ramp from the dark level to unity over the top third, back over the bottom third
    function automatic longint gain_for_row(input longint r);
        longint h;
        longint full;
        longint dk;
        longint top;
        longint low;
        h    = longint'(height_q);
        full = longint'(FIXED_ONE);
        dk   = longint'(dark_q);
        top  = h / 3;
        low  = (h * 2) / 3;
        if (r <= top)
        begin
            if (r == 0)
                return dk;
            if (r >= top)
                return full;
            return dk + (r * (full - dk)) / top;
        end
        if (r >= low && r < h)
        begin
            if (r == low)
                return full;
            return full + ((r - low) * (dk - full)) / (h - low);
        end
        return full;
    endfunction

    function automatic rgb_t tint_pixel(input pixel_t p);
        longint lum;
        longint lvl;
        longint v [LANES];
        rgb_t   res;
        lum = (LUM_COEF_R * longint'(p.red) + LUM_COEF_G * longint'(p.green)
               + LUM_COEF_B * longint'(p.blue)) / 256;
        lum = clamp_to_byte((lum * gain_for_row(longint'(p.row))) / FIXED_ONE);
        lvl = clamp_to_byte((lum * longint'(bgain_q)) / FIXED_ONE
                            + (longint'(coff_q) * 255) / FIXED_ONE);
        for (int k = 0; k < LANES; k++)
        begin
            v[k] = (lvl * longint'(tint_q[k])) / 255;
            if (alpha_on_q && p.alpha != 8'hff)
                v[k] = (v[k] * longint'(p.alpha)) / 255;
        end
        res.red   = v[0][7:0];
        res.green = v[1][7:0];
        res.blue  = v[2][7:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    // Empty table row, every field cleared
    function automatic plan_step_t blank_step();
        plan_step_t st;
        st.is_write = 1'b0;
        st.reg_idx  = REG_TINT_RED;
        st.wdata    = '0;
        st.px       = '{default: '0};
        st.typed    = 1'b0;
        st.want     = '{default: '0};
        return st;
    endfunction

    function automatic void plan_write(input cfg_reg_t idx, input int unsigned v);
        plan_step_t st;
        st          = blank_step();
        st.is_write = 1'b1;
        st.reg_idx  = idx;
        st.wdata    = CFG_DATA_W'(v);
        plan_q.push_back(st);
    endfunction

    function automatic void plan_pix(input int r, input int g, input int b,
                                     input int a, input int rw);
        plan_step_t st;
        st          = blank_step();
        st.px.red   = PIX_W'(r);
        st.px.green = PIX_W'(g);
        st.px.blue  = PIX_W'(b);
        st.px.alpha = PIX_W'(a);
        st.px.row   = ROW_W'(rw);
        plan_q.push_back(st);
    endfunction

    // Pixel with its result typed in
    function automatic void plan_known(input int r, input int g, input int b,
                                       input int a, input int rw,
                                       input int er, input int eg, input int eb);
        plan_pix(r, g, b, a, rw);
        plan_q[$].typed      = 1'b1;
        plan_q[$].want.red   = PIX_W'(er);
        plan_q[$].want.green = PIX_W'(eg);
        plan_q[$].want.blue  = PIX_W'(eb);
    endfunction

    // Mostly random, sometimes the bottom, the typical top or the field top
    function automatic int unsigned pick_level(input int unsigned typ_hi,
                                               input int unsigned field_max);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return typ_hi;
            2: return field_max;
            3: return $urandom_range(typ_hi, field_max);
            default: return $urandom_range(0, typ_hi);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input pixel_t p, input bit typed, input rgb_t want);
        start    <= 1'b1;
        in_red   <= p.red;
        in_green <= p.green;
        in_blue  <= p.blue;
        in_alpha <= p.alpha;
        row      <= p.row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
            tinted_q.push_back(want);
        else
            tinted_q.push_back(tint_pixel(p));
        pixels_sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every predicted pixel has come back
    task automatic drain_pixels();
        start <= 1'b0;
        while (tinted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TINT_RED:        tint_q[0]  = v[PIX_W-1:0];
            REG_TINT_GREEN:      tint_q[1]  = v[PIX_W-1:0];
            REG_TINT_BLUE:       tint_q[2]  = v[PIX_W-1:0];
            REG_IMAGE_HEIGHT:    height_q   = v[H_W-1:0];
            REG_USE_ALPHA:       alpha_on_q = v[0];
            REG_BRIGHTNESS_GAIN: bgain_q    = v[BGAIN_W-1:0];
            REG_CONTRAST_OFFSET: coff_q     = v[COFF_W-1:0];
            REG_DARK_LEVEL:      dark_q     = v[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void check_lane(input string lane, input logic [PIX_W-1:0] got,
                                       input logic [PIX_W-1:0] exp_v);
        if (got !== exp_v)
            flag_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                    results_seen, lane, exp_v, got));
    endfunction

    always @(posedge clk)
    begin : result_check
        rgb_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (tinted_q.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d (%0d %0d %0d) with nothing pending",
                                        results_seen, out_red, out_green, out_blue));
            end
            else
            begin
                want = tinted_q.pop_front();
                check_lane("red", out_red, want.red);
                check_lane("green", out_green, want.green);
                check_lane("blue", out_blue, want.blue);
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        plan_step_t  st;
        pixel_t      px;
        rgb_t        none;
        bit          prev_pix;
        int          phase_len;
        int          sent;
        int          burst;
        int          rand_sent;
        int unsigned top_row;

        none       = '{default: '0};
        prev_pix   = 1'b1;
        rand_sent  = 0;
        for (int k = 0; k < LANES; k++)
            tint_q[k] = RST_TINT;

        rst_n     = 1'b0;
        start     = 1'b0;
        in_red    = '0;
        in_green  = '0;
        in_blue   = '0;
        in_alpha  = '0;
        row       = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-row image, so only row 0 is darkened
        plan_known(0, 0, 0, 0, 0, 30, 30, 30);
        plan_known(255, 255, 255, 255, 0, 98, 98, 98);
        plan_known(255, 255, 255, 0, 1, 255, 255, 255);
        plan_known(255, 255, 255, 128, 4095, 255, 255, 255);

        // Full height, black edges, alpha on, both ramps and their corners
        plan_write(REG_IMAGE_HEIGHT, MAX_HEIGHT);
        plan_write(REG_USE_ALPHA, 1);
        plan_write(REG_TINT_RED, 200);
        plan_write(REG_TINT_GREEN, 100);
        plan_write(REG_TINT_BLUE, 0);
        plan_write(REG_DARK_LEVEL, 0);
        plan_known(255, 255, 255, 0, 0, 0, 0, 0);
        plan_pix(10, 200, 30, 255, 1365);
        plan_pix(128, 128, 128, 128, 700);
        plan_pix(255, 0, 0, 254, 2730);
        plan_pix(0, 255, 0, 1, 3500);
        plan_pix(0, 0, 255, 255, 4095);

        // Zero height, every gain register at its field maximum
        plan_write(REG_IMAGE_HEIGHT, 0);
        plan_write(REG_DARK_LEVEL, 131071);
        plan_write(REG_BRIGHTNESS_GAIN, 262143);
        plan_write(REG_CONTRAST_OFFSET, 131071);
        plan_write(REG_USE_ALPHA, 0);
        plan_write(REG_TINT_RED, 255);
        plan_write(REG_TINT_GREEN, 0);
        plan_write(REG_TINT_BLUE, 255);
        plan_known(0, 0, 0, 0, 0, 255, 0, 255);
        plan_known(255, 255, 255, 0, 5, 255, 0, 255);

        // Largest height, zero gain and offset give a black level
        plan_write(REG_IMAGE_HEIGHT, 8191);
        plan_write(REG_DARK_LEVEL, FIXED_ONE);
        plan_write(REG_BRIGHTNESS_GAIN, 0);
        plan_write(REG_CONTRAST_OFFSET, 0);
        plan_known(255, 255, 255, 255, 4095, 0, 0, 0);

        // Seven rows, dark level above unity so both ramps are inverted
        plan_write(REG_IMAGE_HEIGHT, 7);
        plan_write(REG_DARK_LEVEL, 131071);
        plan_write(REG_BRIGHTNESS_GAIN, FIXED_ONE);
        plan_write(REG_TINT_GREEN, 128);
        plan_write(REG_TINT_BLUE, 1);
        plan_write(REG_USE_ALPHA, 1);
        plan_pix(200, 150, 100, 255, 0);
        plan_pix(200, 150, 100, 170, 1);
        plan_pix(255, 255, 255, 85, 2);
        plan_pix(60, 70, 80, 255, 3);
        plan_pix(255, 255, 255, 254, 4);
        plan_pix(120, 240, 30, 0, 5);
        plan_pix(255, 200, 10, 255, 6);

        // Walk the directed table
        foreach (plan_q[i])
        begin
            st = plan_q[i];
            if (st.is_write)
            begin
                if (prev_pix)
                begin
                    drain_pixels();
                    repeat (SETTLE) @(posedge clk);
                    settings_cnt++;
                end
                write_reg(st.reg_idx, st.wdata);
                prev_pix = 1'b0;
            end
            else
            begin
                send_pixel(st.px, st.typed, st.want);
                pause_sender($urandom_range(0, 3));
                prev_pix = 1'b1;
            end
        end

        // Random phases, each with fresh register settings
        while (rand_sent < RAND_ITEMS)
        begin
            drain_pixels();
            repeat (SETTLE) @(posedge clk);
            settings_cnt++;
            write_reg(REG_TINT_RED, CFG_DATA_W'(pick_level(255, 255)));
            write_reg(REG_TINT_GREEN, CFG_DATA_W'(pick_level(255, 255)));
            write_reg(REG_TINT_BLUE, CFG_DATA_W'(pick_level(255, 255)));
            case ($urandom_range(0, 9))
                0:       write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
                1:       write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
                2:       write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
                3, 4, 5: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 12)));
                default: write_reg(REG_IMAGE_HEIGHT,
                                   CFG_DATA_W'($urandom_range(13, MAX_HEIGHT)));
            endcase
            write_reg(REG_USE_ALPHA, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_BRIGHTNESS_GAIN, CFG_DATA_W'(pick_level(131072, 262143)));
            write_reg(REG_CONTRAST_OFFSET, CFG_DATA_W'(pick_level(32768, 131071)));
            write_reg(REG_DARK_LEVEL, CFG_DATA_W'(pick_level(FIXED_ONE, 131071)));

            phase_len = $urandom_range(60, 160);
            sent      = 0;
            while (sent < phase_len)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < phase_len; k++)
                begin
                    px.red   = pick_byte();
                    px.green = pick_byte();
                    px.blue  = pick_byte();
                    case ($urandom_range(0, 5))
                        0, 1:    px.alpha = 8'hff;
                        2:       px.alpha = 8'h00;
                        default: px.alpha = PIX_W'($urandom_range(0, 255));
                    endcase
                    // Mostly rows inside the image, where the bands live
                    if (height_q != 0 && $urandom_range(0, 3) != 0)
                    begin
                        top_row  = (height_q > MAX_HEIGHT) ? MAX_HEIGHT - 1 : height_q - 1;
                        px.row   = ROW_W'($urandom_range(0, top_row));
                    end
                    else
                    begin
                        px.row = ROW_W'($urandom_range(0, MAX_HEIGHT - 1));
                    end
                    send_pixel(px, 1'b0, none);
                    sent++;
                    rand_sent++;
                end
                case ($urandom_range(0, 9))
                    0:       drain_pixels();
                    1, 2:    ;
                    default: pause_sender($urandom_range(1, 8));
                endcase
            end
        end

        // Let the pipeline empty, then watch for stray results
        drain_pixels();
        repeat (PIPE_LAT + SETTLE) @(posedge clk);

        $display("run: %0d pixels sent, %0d results compared, %0d register settings",
                 pixels_sent, results_seen, settings_cnt);
        $display("run: %0d lane mismatches, %0d results still pending",
                 fault_cnt, tinted_q.size());
        if (fault_cnt == 0 && tinted_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
